// ===== design/hpd_pkg.sv =====
// hpd_pkg: widths, register indices, reset values and the configuration bundle
// shared by the heading pid duty unit; depends on nothing else
package hpd_pkg;

	localparam int GAIN_FRAC_BITS = 8;

	localparam int GAIN_W  = 16;
	localparam int ERR_W   = 10;
	localparam int DUTY_W  = 7;
	localparam int STEP_W  = 8;
	localparam int INTEG_W = 16;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 16;

	// product and sum widths, all signed
	localparam int P_W   = ERR_W + GAIN_W + 1;
	localparam int D_W   = ERR_W + GAIN_W + 2;
	localparam int I_W   = INTEG_W + GAIN_W + 1;
	localparam int SUM_W = I_W + 2;
	localparam int Q_W   = SUM_W - GAIN_FRAC_BITS;

	localparam int HALF_TURN   = 180;
	localparam int FULL_TURN   = 360;
	localparam int INTEG_LIMIT = 32767;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = '0;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = '0;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = '0;
	localparam logic [DUTY_W-1:0] MIN_DUTY_RST   = 7'd1;
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST   = 7'd70;
	localparam logic [DUTY_W-1:0] TERM_CLAMP_RST = 7'd10;
	localparam logic [STEP_W-1:0] STEP_CLAMP_RST = 8'd30;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_MIN_DUTY   = 3'd3,
		REG_MAX_DUTY   = 3'd4,
		REG_TERM_CLAMP = 3'd5,
		REG_STEP_CLAMP = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [DUTY_W-1:0] min_duty;
		logic [DUTY_W-1:0] max_duty;
		logic [DUTY_W-1:0] term_clamp;
		logic [STEP_W-1:0] integral_step_clamp;
	} cfg_t;

endpackage

// ===== design/hpd_cfg_regs.sv =====
// hpd_cfg_regs: register file for gains and limits, written over the config channel
// depends on hpd_pkg
module hpd_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [hpd_pkg::IDX_W-1:0] wr_index,
	input  logic [hpd_pkg::CFG_W-1:0] wr_data,
	output hpd_pkg::cfg_t             cfg
);

	hpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain           <= hpd_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain          <= hpd_pkg::INTEG_GAIN_RST;
			cfg_q.deriv_gain          <= hpd_pkg::DERIV_GAIN_RST;
			cfg_q.min_duty            <= hpd_pkg::MIN_DUTY_RST;
			cfg_q.max_duty            <= hpd_pkg::MAX_DUTY_RST;
			cfg_q.term_clamp          <= hpd_pkg::TERM_CLAMP_RST;
			cfg_q.integral_step_clamp <= hpd_pkg::STEP_CLAMP_RST;
		end else if (wr_en) begin
			case (hpd_pkg::cfg_reg_t'(wr_index))
				hpd_pkg::REG_PROP_GAIN:  cfg_q.prop_gain  <= wr_data;
				hpd_pkg::REG_INTEG_GAIN: cfg_q.integ_gain <= wr_data;
				hpd_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain <= wr_data;
				hpd_pkg::REG_MIN_DUTY:   cfg_q.min_duty   <= wr_data[hpd_pkg::DUTY_W-1:0];
				hpd_pkg::REG_MAX_DUTY:   cfg_q.max_duty   <= wr_data[hpd_pkg::DUTY_W-1:0];
				hpd_pkg::REG_TERM_CLAMP: cfg_q.term_clamp <= wr_data[hpd_pkg::DUTY_W-1:0];
				hpd_pkg::REG_STEP_CLAMP:
					cfg_q.integral_step_clamp <= wr_data[hpd_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/hpd_fold.sv =====
// hpd_fold: heading error folded once onto the shorter turn, then limited to a full turn
// depends on hpd_pkg
module hpd_fold (
	input  logic signed [hpd_pkg::ERR_W-1:0] target_heading,
	input  logic signed [hpd_pkg::ERR_W-1:0] measured_heading,
	output logic signed [hpd_pkg::ERR_W-1:0] signed_error
);

	localparam int DW = hpd_pkg::ERR_W + 1;
	localparam int MW = hpd_pkg::ERR_W + 2;

	logic signed [DW-1:0] diff;
	logic signed [MW-1:0] mag;
	logic signed [MW-1:0] mag_f;
	logic signed [MW-1:0] err_f;
	logic                 cw;
	logic                 flip;

	always_comb begin
		diff  = DW'(target_heading) - DW'(measured_heading);
		cw    = !diff[DW-1];
		mag   = cw ? MW'(diff) : -MW'(diff);
		flip  = mag > MW'(hpd_pkg::HALF_TURN);
		// long way round becomes the short way in the other direction
		mag_f = flip ? MW'(hpd_pkg::FULL_TURN) - mag : mag;
		err_f = (cw ^ flip) ? mag_f : -mag_f;
		if (err_f > MW'(hpd_pkg::FULL_TURN))
			signed_error = hpd_pkg::ERR_W'(hpd_pkg::FULL_TURN);
		else if (err_f < -MW'(hpd_pkg::FULL_TURN))
			signed_error = -hpd_pkg::ERR_W'(hpd_pkg::FULL_TURN);
		else
			signed_error = err_f[hpd_pkg::ERR_W-1:0];
	end

endmodule

// ===== design/hpd_law.sv =====
// hpd_law: loop state and pid control law, one tick per advance
// depends on hpd_pkg
module hpd_law (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              enabled,
	input  logic signed [hpd_pkg::ERR_W-1:0]  err,
	input  hpd_pkg::cfg_t                     cfg,
	output logic        [hpd_pkg::DUTY_W-1:0] motor_duty,
	output logic signed [hpd_pkg::ERR_W-1:0]  signed_error
);

	localparam int F    = hpd_pkg::GAIN_FRAC_BITS;
	localparam int SW   = hpd_pkg::ERR_W + 1;
	localparam int AW   = hpd_pkg::INTEG_W + 1;
	localparam int GS_W = hpd_pkg::GAIN_W + 1;

	logic signed [hpd_pkg::INTEG_W-1:0] integ_q;
	logic signed [hpd_pkg::ERR_W-1:0]   prev_err_q;
	logic        [hpd_pkg::DUTY_W-1:0]  prev_duty_q;

	logic                               run_integ;
	logic signed [SW-1:0]               err_e;
	logic signed [SW-1:0]               step_lim;
	logic signed [SW-1:0]               step;
	logic signed [AW-1:0]               acc;
	logic signed [hpd_pkg::INTEG_W-1:0] integ_nx;
	logic signed [SW-1:0]               err_diff;
	logic signed [hpd_pkg::P_W-1:0]     p_raw;
	logic signed [hpd_pkg::P_W-1:0]     p_lim;
	logic signed [hpd_pkg::P_W-1:0]     p_c;
	logic signed [hpd_pkg::D_W-1:0]     d_raw;
	logic signed [hpd_pkg::D_W-1:0]     d_lim;
	logic signed [hpd_pkg::D_W-1:0]     d_c;
	logic signed [hpd_pkg::I_W-1:0]     i_raw;
	logic signed [hpd_pkg::SUM_W-1:0]   sum;
	logic signed [hpd_pkg::SUM_W-1:0]   sum_b;
	logic signed [hpd_pkg::Q_W-1:0]     q;
	logic signed [hpd_pkg::Q_W-1:0]     q_hi;
	logic signed [hpd_pkg::Q_W-1:0]     q_c;
	logic        [hpd_pkg::DUTY_W-1:0]  duty;

	always_comb begin
		// integrator only moves while the last duty sat inside the limits
		run_integ = (prev_duty_q > cfg.min_duty) && (prev_duty_q < cfg.max_duty);
		err_e     = SW'(err);
		step_lim  = $signed({{(SW-hpd_pkg::STEP_W){1'b0}}, cfg.integral_step_clamp});
		if (err_e > step_lim)
			step = step_lim;
		else if (err_e < -step_lim)
			step = -step_lim;
		else
			step = err_e;
		acc = AW'(integ_q) + AW'(step);
		if (!run_integ)
			integ_nx = integ_q;
		else if (acc > AW'(hpd_pkg::INTEG_LIMIT))
			integ_nx = hpd_pkg::INTEG_W'(hpd_pkg::INTEG_LIMIT);
		else if (acc < -AW'(hpd_pkg::INTEG_LIMIT))
			integ_nx = -hpd_pkg::INTEG_W'(hpd_pkg::INTEG_LIMIT);
		else
			integ_nx = acc[hpd_pkg::INTEG_W-1:0];

		p_raw = err * $signed({1'b0, cfg.prop_gain});
		p_lim = $signed({{(hpd_pkg::P_W-hpd_pkg::DUTY_W-F){1'b0}}, cfg.term_clamp,
			{F{1'b0}}});
		if (p_raw > p_lim)
			p_c = p_lim;
		else if (p_raw < -p_lim)
			p_c = -p_lim;
		else
			p_c = p_raw;

		err_diff = SW'(err) - SW'(prev_err_q);
		d_raw    = err_diff * $signed({1'b0, cfg.deriv_gain});
		d_lim    = hpd_pkg::D_W'(p_lim);
		if (d_raw > d_lim)
			d_c = d_lim;
		else if (d_raw < -d_lim)
			d_c = -d_lim;
		else
			d_c = d_raw;

		i_raw = integ_nx * $signed(GS_W'({1'b0, cfg.integ_gain}));

		sum   = hpd_pkg::SUM_W'(p_c) + hpd_pkg::SUM_W'(i_raw) + hpd_pkg::SUM_W'(d_c);
		// bias negative sums so the shift truncates toward zero
		sum_b = sum + (sum[hpd_pkg::SUM_W-1] ?
			hpd_pkg::SUM_W'({F{1'b1}}) : hpd_pkg::SUM_W'(0));
		q     = sum_b[hpd_pkg::SUM_W-1:F];

		// max first, then min, so an inverted pair leaves min_duty
		q_hi = (q > $signed(hpd_pkg::Q_W'(cfg.max_duty))) ?
			$signed(hpd_pkg::Q_W'(cfg.max_duty)) : q;
		q_c  = (q_hi < $signed(hpd_pkg::Q_W'(cfg.min_duty))) ?
			$signed(hpd_pkg::Q_W'(cfg.min_duty)) : q_hi;
		duty = q_c[hpd_pkg::DUTY_W-1:0];

		motor_duty   = enabled ? duty : '0;
		signed_error = enabled ? err : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_err_q  <= '0;
			prev_duty_q <= '0;
		end else if (advance) begin
			if (!enabled) begin
				integ_q     <= '0;
				prev_err_q  <= '0;
				prev_duty_q <= '0;
			end else begin
				integ_q     <= integ_nx;
				prev_err_q  <= err;
				prev_duty_q <= duty;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !enabled |=> integ_q == '0 && prev_duty_q == '0 && prev_err_q == '0)
		else $error("loop state not cleared by a disabled tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(integ_q) && $stable(prev_duty_q) && $stable(prev_err_q))
		else $error("loop state moved without a tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		integ_q != {1'b1, {(hpd_pkg::INTEG_W-1){1'b0}}})
		else $error("integrator left its saturation range");

endmodule

// ===== design/heading_pid_duty_shortest_turn_unit.sv =====
// heading_pid_duty_shortest_turn_unit: top level of the heading pid duty unit
// depends on hpd_pkg, hpd_cfg_regs, hpd_fold and hpd_law
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: target, measured; tuser: enabled
//  m_*      | out       | m_tvalid/m_tready  | tdata: motor_duty, signed_error
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one tick per clock cycle sustained while the output is not stalled; a tick's result
// reaches m_tdata via the error fold into the input register at its transfer edge, then
// the control law into the result register when it advances, which also updates the
// integrator and previous error/duty.
// reset clears the loop state and loads the register defaults; no clearing pass.
// a stalled output holds its result and the input register, and s_tready drops
// only while both are full.
module heading_pid_duty_shortest_turn_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] target_heading, [19:10] measured_heading, pad
	input  logic [0:0]  s_tuser,   // [0] enabled
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] motor_duty, [16:7] signed_error, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [hpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [hpd_pkg::CFG_W-1:0] cfg_data
);

	localparam int OUT_USED = hpd_pkg::DUTY_W + hpd_pkg::ERR_W;

	hpd_pkg::cfg_t cfg;

	logic                              valid_s1;
	logic                              en_s1;
	logic signed [hpd_pkg::ERR_W-1:0]  err_s1;
	logic signed [hpd_pkg::ERR_W-1:0]  fold_err;
	logic                              m_valid_q;
	logic        [hpd_pkg::DUTY_W-1:0] duty_q;
	logic signed [hpd_pkg::ERR_W-1:0]  serr_q;
	logic        [hpd_pkg::DUTY_W-1:0] law_duty;
	logic signed [hpd_pkg::ERR_W-1:0]  law_err;
	logic                              advance;
	logic                              s_xfer;

	assign cfg_ready = 1'b1;

	hpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	hpd_fold u_fold (
		.target_heading   ($signed(s_tdata[hpd_pkg::ERR_W-1:0])),
		.measured_heading ($signed(s_tdata[2*hpd_pkg::ERR_W-1:hpd_pkg::ERR_W])),
		.signed_error     (fold_err)
	);

	// result register free, or emptied this cycle
	assign advance  = !m_valid_q || m_tready;
	assign s_tready = advance || !valid_s1;
	assign s_xfer   = s_tvalid && s_tready;

	hpd_law u_law (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance && valid_s1),
		.enabled      (en_s1),
		.err          (err_s1),
		.cfg          (cfg),
		.motor_duty   (law_duty),
		.signed_error (law_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			en_s1  <= s_tuser[0];
			err_s1 <= fold_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			duty_q <= law_duty;
			serr_q <= law_err;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(24-OUT_USED){1'b0}}, serr_q, duty_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(err_s1) && $stable(en_s1))
		else $error("waiting tick lost from the input register");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready && valid_s1 |-> !s_tready)
		else $error("input taken while both registers are full");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && !en_s1 |=> m_valid_q && duty_q == '0 && serr_q == '0)
		else $error("disabled tick gave a non-zero result");

endmodule

// ===== verif/heading_pid_duty_shortest_turn_unit_tb.sv =====
// testbench for heading_pid_duty_shortest_turn_unit: a table of directed ticks and register
// writes, then random and integrator wind-up phases, each duty checked against table or predictor
// depends on hpd_pkg and the design top level
module heading_pid_duty_shortest_turn_unit_tb;

	// longest quiet stretch in a good run is the receiver hold-off; this is many times that
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int MAX_REPORTS     = 40;

	localparam logic [hpd_pkg::IDX_W-1:0]        REG_UNMAPPED = 3'd7;
	localparam logic signed [hpd_pkg::ERR_W-1:0] HEAD_TOP     = 10'sh1FF;
	localparam logic signed [hpd_pkg::ERR_W-1:0] HEAD_BOTTOM  = 10'sh200;

	typedef struct packed {
		logic                              enabled;
		logic signed [hpd_pkg::ERR_W-1:0]  target;
		logic signed [hpd_pkg::ERR_W-1:0]  measured;
	} tick_t;

	typedef struct packed {
		logic [hpd_pkg::DUTY_W-1:0]        duty;
		logic signed [hpd_pkg::ERR_W-1:0]  err;
	} duty_result_t;

	typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [hpd_pkg::IDX_W-1:0]   index;
		logic [hpd_pkg::CFG_W-1:0]   value;
		tick_t                       tk;
		logic                        typed;
		duty_result_t                res;
	} dir_row_t;

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [23:0]                s_tdata;   // [9:0] target_heading, [19:10] measured_heading, pad
	logic [0:0]                 s_tuser;   // [0] enabled
	logic                       m_tvalid;
	logic                       m_tready;
	logic [23:0]                m_tdata;   // [6:0] motor_duty, [16:7] signed_error, pad
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [hpd_pkg::IDX_W-1:0]  cfg_index;
	logic [hpd_pkg::CFG_W-1:0]  cfg_data;

	// predictor copy of the registers and loop state
	hpd_pkg::cfg_t  law_cfg;
	int             integ_acc;
	int             last_err;
	int             last_duty;

	duty_result_t  duty_expect_q[$];
	dir_row_t      dir_rows[$];
	int            fail_count = 0;
	int            burst_left = 0;
	int            quiet_cycles = 0;
	bit            hold_off_req = 1'b0;

	heading_pid_duty_shortest_turn_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sym_limit(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// one control tick: fold, three terms, truncate, duty limits; updates the loop state
	function automatic duty_result_t heading_law_step(input tick_t tk);
		duty_result_t r;
		longint unit_scale, err, mag, lim, p, ip, d, sum, q;
		bit cw;
		unit_scale = longint'(1) << hpd_pkg::GAIN_FRAC_BITS;
		if (!tk.enabled) begin
			integ_acc = 0;
			last_err  = 0;
			last_duty = 0;
			r = '0;
			return r;
		end
		err = longint'($signed(tk.target)) - longint'($signed(tk.measured));
		cw  = (err >= 0);
		mag = cw ? err : -err;
		if (mag > hpd_pkg::HALF_TURN) begin
			mag = hpd_pkg::FULL_TURN - mag;
			cw  = !cw;
		end
		err = sym_limit(cw ? mag : -mag, hpd_pkg::FULL_TURN);
		lim = longint'(law_cfg.term_clamp) * unit_scale;
		p = sym_limit(err * longint'(law_cfg.prop_gain), lim);
		// no integration while the last duty sat on either limit
		if (last_duty > int'(law_cfg.min_duty) && last_duty < int'(law_cfg.max_duty))
			integ_acc = int'(sym_limit(longint'(integ_acc) +
				sym_limit(err, longint'(law_cfg.integral_step_clamp)),
				hpd_pkg::INTEG_LIMIT));
		ip = longint'(integ_acc) * longint'(law_cfg.integ_gain);
		d = sym_limit((err - longint'(last_err)) * longint'(law_cfg.deriv_gain), lim);
		last_err = int'(err);
		sum = p + ip + d;
		q = sum / unit_scale;
		if (q > longint'(law_cfg.max_duty)) q = longint'(law_cfg.max_duty);
		if (q < longint'(law_cfg.min_duty)) q = longint'(law_cfg.min_duty);
		last_duty = int'(q) & 'h7F;
		r.duty = hpd_pkg::DUTY_W'(q);
		r.err  = hpd_pkg::ERR_W'(err);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s: expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	task automatic add_cfg(input logic [hpd_pkg::IDX_W-1:0] idx,
			input logic [hpd_pkg::CFG_W-1:0] word);
		dir_row_t row;
		row = '0;
		row.kind  = ROW_CFG;
		row.index = idx;
		row.value = word;
		dir_rows.push_back(row);
	endtask

	task automatic add_tick(input logic en, input int tgt, input int meas,
			input bit typed = 1'b0, input int x_duty = 0, input int x_err = 0);
		dir_row_t row;
		row = '0;
		row.kind        = ROW_TICK;
		row.tk.enabled  = en;
		row.tk.target   = hpd_pkg::ERR_W'(tgt);
		row.tk.measured = hpd_pkg::ERR_W'(meas);
		row.typed       = typed;
		row.res.duty    = hpd_pkg::DUTY_W'(x_duty);
		row.res.err     = hpd_pkg::ERR_W'(x_err);
		dir_rows.push_back(row);
	endtask

	task automatic write_reg(input logic [hpd_pkg::IDX_W-1:0] idx,
			input logic [hpd_pkg::CFG_W-1:0] word);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			hpd_pkg::REG_PROP_GAIN:  law_cfg.prop_gain           = word;
			hpd_pkg::REG_INTEG_GAIN: law_cfg.integ_gain          = word;
			hpd_pkg::REG_DERIV_GAIN: law_cfg.deriv_gain          = word;
			hpd_pkg::REG_MIN_DUTY:   law_cfg.min_duty            = word[hpd_pkg::DUTY_W-1:0];
			hpd_pkg::REG_MAX_DUTY:   law_cfg.max_duty            = word[hpd_pkg::DUTY_W-1:0];
			hpd_pkg::REG_TERM_CLAMP: law_cfg.term_clamp          = word[hpd_pkg::DUTY_W-1:0];
			hpd_pkg::REG_STEP_CLAMP:
				law_cfg.integral_step_clamp = word[hpd_pkg::STEP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// sender stands back until every duty is out and the pipeline has gone quiet
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (duty_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic offer_tick(input tick_t tk, input bit typed, input duty_result_t typed_res);
		int gap;
		duty_result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, tk.measured, tk.target};
		s_tuser  <= tk.enabled;
		do @(posedge clk); while (!s_tready);
		r = heading_law_step(tk);
		duty_expect_q.push_back(typed ? typed_res : r);
	endtask

	function automatic tick_t random_tick();
		tick_t tk;
		int t;
		tk.enabled = ($urandom_range(0, 24) != 0);
		case ($urandom_range(0, 9))
			0, 1: begin
				tk.target   = hpd_pkg::ERR_W'($urandom);
				tk.measured = hpd_pkg::ERR_W'($urandom);
			end
			2, 3, 4, 5: begin
				tk.target   = hpd_pkg::ERR_W'(int'($urandom_range(0, 720)) - 360);
				tk.measured = hpd_pkg::ERR_W'(int'($urandom_range(0, 720)) - 360);
			end
			default: begin
				// small error keeps the duty off its limits so the integrator moves
				t = int'($urandom_range(0, 720)) - 360;
				tk.target   = hpd_pkg::ERR_W'(t);
				tk.measured = hpd_pkg::ERR_W'(t + int'($urandom_range(0, 40)) - 20);
			end
		endcase
		return tk;
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 'hFFFF;
			2:       return $urandom_range(0, 'h300);
			default: return $urandom_range(0, 'hFFFF);
		endcase
	endfunction

	// junk above the register width now and then
	function automatic logic [hpd_pkg::CFG_W-1:0] cfg_word(input int v, input int w);
		if ($urandom_range(0, 1)) return hpd_pkg::CFG_W'(v);
		return hpd_pkg::CFG_W'(($urandom << w) | v);
	endfunction

	task automatic randomize_config();
		int lo_duty, hi_duty, term;
		drain_results();
		lo_duty = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 127 : 0)
			: $urandom_range(0, 15);
		hi_duty = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 127 : 0)
			: $urandom_range(40, 100);
		term = ($urandom_range(0, 4) == 0) ? 127 : $urandom_range(0, 100);
		write_reg(hpd_pkg::REG_PROP_GAIN, cfg_word(pick_gain(), hpd_pkg::GAIN_W));
		write_reg(hpd_pkg::REG_INTEG_GAIN, cfg_word(pick_gain(), hpd_pkg::GAIN_W));
		write_reg(hpd_pkg::REG_DERIV_GAIN, cfg_word(pick_gain(), hpd_pkg::GAIN_W));
		write_reg(hpd_pkg::REG_MIN_DUTY, cfg_word(lo_duty, hpd_pkg::DUTY_W));
		write_reg(hpd_pkg::REG_MAX_DUTY, cfg_word(hi_duty, hpd_pkg::DUTY_W));
		write_reg(hpd_pkg::REG_TERM_CLAMP, cfg_word(term, hpd_pkg::DUTY_W));
		write_reg(hpd_pkg::REG_STEP_CLAMP, cfg_word($urandom_range(0, 255), hpd_pkg::STEP_W));
		if ($urandom_range(0, 1))
			write_reg(REG_UNMAPPED, hpd_pkg::CFG_W'($urandom));
	endtask

	task automatic random_phase(input int n_ticks);
		randomize_config();
		for (int k = 0; k < n_ticks; k++) begin
			if (k == 10)
				hold_off_req = 1'b1;
			if (k == n_ticks / 2)
				drain_results();
			offer_tick(random_tick(), 1'b0, '0);
		end
	endtask

	// drives the integrator into saturation: upward on a steady full error through the
	// proportional term, downward on alternating errors through the derivative term
	task automatic windup_phase(input bit upward, input int n_ticks);
		tick_t tk;
		drain_results();
		write_reg(hpd_pkg::REG_PROP_GAIN, upward ? 16'h0100 : 16'h0000);
		write_reg(hpd_pkg::REG_INTEG_GAIN, 16'h0000);
		write_reg(hpd_pkg::REG_DERIV_GAIN, upward ? 16'h0000 : 16'hFFFF);
		write_reg(hpd_pkg::REG_MIN_DUTY, 16'd0);
		write_reg(hpd_pkg::REG_MAX_DUTY, 16'd127);
		write_reg(hpd_pkg::REG_TERM_CLAMP, 16'd100);
		write_reg(hpd_pkg::REG_STEP_CLAMP, 16'd255);
		tk = '0;
		offer_tick(tk, 1'b0, '0);
		tk.enabled = 1'b1;
		for (int k = 0; k < n_ticks; k++) begin
			if (upward) begin
				tk.target   = HEAD_TOP;
				tk.measured = HEAD_BOTTOM;
			end else if (k % 2 == 0) begin
				tk.target   = HEAD_BOTTOM;
				tk.measured = HEAD_TOP;
			end else begin
				tk.target   = hpd_pkg::ERR_W'(-hpd_pkg::HALF_TURN);
				tk.measured = '0;
			end
			offer_tick(tk, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : duty_check
		duty_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (duty_expect_q.size() == 0) begin
				report_mismatch("duty transfer with nothing pending", -1, int'(m_tdata[6:0]));
			end else begin
				want = duty_expect_q.pop_front();
				if (m_tdata[6:0] !== want.duty)
					report_mismatch("motor_duty", want.duty, m_tdata[6:0]);
				if ($signed(m_tdata[16:7]) !== want.err)
					report_mismatch("signed_error", want.err, $signed(m_tdata[16:7]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : rx_pace
		rx_mode_t mode;
		int seg_left;
		int beat;
		m_tready = 1'b0;
		mode = RX_FREE;
		seg_left = 0;
		beat = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				// long stall so the block fills up and drops s_tready
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(1, 40);
				end
				seg_left--;
				beat++;
				case (mode)
					RX_FREE:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
					RX_BEAT:   m_tready <= (beat % 4 != 3);
					default:   m_tready <= 1'b1;
				endcase
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		law_cfg.prop_gain           = hpd_pkg::PROP_GAIN_RST;
		law_cfg.integ_gain          = hpd_pkg::INTEG_GAIN_RST;
		law_cfg.deriv_gain          = hpd_pkg::DERIV_GAIN_RST;
		law_cfg.min_duty            = hpd_pkg::MIN_DUTY_RST;
		law_cfg.max_duty            = hpd_pkg::MAX_DUTY_RST;
		law_cfg.term_clamp          = hpd_pkg::TERM_CLAMP_RST;
		law_cfg.integral_step_clamp = hpd_pkg::STEP_CLAMP_RST;
		integ_acc = 0;
		last_err  = 0;
		last_duty = 0;

		// register defaults, zero gains: every enabled duty is lifted to min_duty
		add_tick(0, 0, 0, 1, 0, 0);
		add_tick(1, 0, 0, 1, 1, 0);
		add_tick(1, 180, 0, 1, 1, 180);       // half turn stays as it is
		add_tick(1, 181, 0, 1, 1, -179);      // just past half turn turns the other way
		add_tick(1, 270, 0, 1, 1, -90);
		add_tick(1, -360, 360, 1, 1, -360);
		add_tick(1, 360, -360, 1, 1, 360);
		add_tick(1, 511, -512, 1, 1, 360);    // folded errors beyond a full turn saturate
		add_tick(1, -512, 511, 1, 1, -360);
		add_tick(1, -512, -512, 1, 1, 0);
		add_cfg(hpd_pkg::REG_PROP_GAIN, 16'h0100);
		add_cfg(hpd_pkg::REG_MIN_DUTY, 16'd0);
		add_cfg(hpd_pkg::REG_MAX_DUTY, 16'd100);
		add_cfg(hpd_pkg::REG_TERM_CLAMP, 16'd100);
		add_tick(1, 50, 0, 1, 50, 50);
		add_tick(1, 0, 50, 1, 0, -50);
		// full gain against a tight term limit
		add_cfg(hpd_pkg::REG_PROP_GAIN, 16'hFFFF);
		add_cfg(hpd_pkg::REG_TERM_CLAMP, 16'd10);
		add_tick(1, 90, 0, 1, 10, 90);
		add_tick(1, -90, 0, 1, 0, -90);
		add_cfg(hpd_pkg::REG_TERM_CLAMP, 16'd0);
		add_tick(1, 90, 0, 1, 0, 90);
		// inverted duty limits: min_duty wins
		add_cfg(hpd_pkg::REG_PROP_GAIN, 16'h0000);
		add_cfg(hpd_pkg::REG_MIN_DUTY, 16'd60);
		add_cfg(hpd_pkg::REG_MAX_DUTY, 16'd20);
		add_tick(1, 10, 0, 1, 60, 10);
		add_cfg(hpd_pkg::REG_PROP_GAIN, 16'h0200);
		add_cfg(hpd_pkg::REG_INTEG_GAIN, 16'h0040);
		add_cfg(hpd_pkg::REG_DERIV_GAIN, 16'h0180);
		add_cfg(hpd_pkg::REG_MIN_DUTY, 16'd1);
		add_cfg(hpd_pkg::REG_MAX_DUTY, 16'd100);
		add_cfg(hpd_pkg::REG_TERM_CLAMP, 16'd100);
		add_cfg(hpd_pkg::REG_STEP_CLAMP, 16'd180);
		add_tick(1, 30, 0);
		add_tick(1, 30, 10);
		add_tick(1, -20, 0);
		add_tick(1, 100, -100);
		add_tick(1, -170, 170);
		add_tick(1, 5, 0);
		// unmapped index is dropped; upper data bits are cut off by the register width
		add_cfg(hpd_pkg::REG_STEP_CLAMP, 16'd0);
		add_cfg(REG_UNMAPPED, 16'hFFFF);
		add_cfg(hpd_pkg::REG_MIN_DUTY, 16'hFFFF);
		add_cfg(hpd_pkg::REG_MAX_DUTY, 16'hFFFF);
		add_tick(1, 0, 0, 1, 127, 0);
		add_tick(1, 45, 0);
		add_tick(0, 300, -300, 1, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(dir_rows[i].index, dir_rows[i].value);
			end else begin
				offer_tick(dir_rows[i].tk, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		random_phase(55);
		random_phase(55);
		windup_phase(1'b1, 140);
		random_phase(55);
		windup_phase(1'b0, 280);
		random_phase(55);

		drain_results();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hpd_pkg.sv
design/hpd_cfg_regs.sv
design/hpd_fold.sv
design/hpd_law.sv
design/heading_pid_duty_shortest_turn_unit.sv
verif/heading_pid_duty_shortest_turn_unit_tb.sv
